/* hdl/mbw_pkg.sv */
// shared constants, types and helper functions of the maze walk block
`timescale 1ns / 1ps

package mbw_pkg;

  // grid and stack geometry
  localparam int GRID_COLUMNS = 80;
  localparam int GRID_ROWS    = 21;
  localparam int STACK_DEPTH  = 420;

  // field widths
  localparam int X_W   = 7;
  localparam int Y_W   = 5;
  localparam int RND_W = 8;
  localparam int EV_W  = 2;

  localparam int CELLS    = GRID_COLUMNS * GRID_ROWS;
  localparam int CELL_AW  = $clog2(CELLS);
  localparam int STACK_AW = $clog2(STACK_DEPTH);
  localparam int COUNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ENTRY_W  = X_W + Y_W;

  // carving bounds
  localparam int EDGE_LO = 3;
  localparam int MAX_X   = GRID_COLUMNS - 3;
  localparam int MAX_Y   = GRID_ROWS - 3;

  // directions, tested in this order
  localparam int DIRS  = 4;
  localparam int DIR_W = 2;
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;
  localparam int CNT_W = $clog2(DIRS + 1);

  // divide by three of an 8-bit value: (v * 171) >> 9 is exact below 256
  localparam int DIV3       = 3;
  localparam int RECIP_MUL  = 171;
  localparam int RECIP_SHFT = 9;
  localparam int PROD_W     = RND_W + 8;

  typedef enum logic [EV_W-1:0] {
    EV_CARVED = 2'd0,
    EV_BACK   = 2'd1,
    EV_FINISH = 2'd2
  } event_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_START,
    ST_FIN,
    ST_TOP,
    ST_LOOK,
    ST_CHOOSE,
    ST_POP,
    ST_WALL,
    ST_TGT
  } state_e;

  typedef struct packed {
    event_e         ev;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic           last;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [CELL_AW-1:0] waddr;
    logic               wdata;
    logic               re;
    logic [CELL_AW-1:0] raddr;
  } vis_req_t;

  typedef struct packed {
    logic                we;
    logic [STACK_AW-1:0] waddr;
    logic [ENTRY_W-1:0]  wdata;
    logic                re;
    logic [STACK_AW-1:0] raddr;
  } stk_req_t;

  // linear square address, row major
  function automatic logic [CELL_AW-1:0] cell_addr(input logic [X_W:0] x,
                                                   input logic [Y_W:0] y);
    logic [31:0] full;
    full = 32'(y) * 32'(GRID_COLUMNS) + 32'(x);
    return full[CELL_AW-1:0];
  endfunction

  // direction of open square number (rnd mod count)
  function automatic logic [DIR_W-1:0] pick_dir(input logic [DIRS-1:0]  open,
                                                input logic [RND_W-1:0] rnd);
    logic [CNT_W-1:0]  cnt;
    logic [PROD_W-1:0] prod;
    logic [RND_W-1:0]  quo;
    logic [RND_W-1:0]  rem3;
    logic [DIR_W-1:0]  idx;
    logic [CNT_W-1:0]  seen;
    logic [DIR_W-1:0]  dir;
    cnt = '0;
    for (int d = 0; d < DIRS; d++) begin
      cnt = cnt + CNT_W'(open[d]);
    end
    prod = PROD_W'(rnd) * PROD_W'(RECIP_MUL);
    quo  = RND_W'(prod >> RECIP_SHFT);
    rem3 = rnd - RND_W'(quo * RND_W'(DIV3));
    case (cnt)
      3'd2:    idx = {1'b0, rnd[0]};
      3'd3:    idx = rem3[DIR_W-1:0];
      3'd4:    idx = rnd[DIR_W-1:0];
      default: idx = '0;
    endcase
    seen = '0;
    dir  = DIR_UP;
    for (int d = 0; d < DIRS; d++) begin
      if (open[d]) begin
        if (seen == {1'b0, idx}) begin
          dir = DIR_W'(d);
        end
        seen = seen + CNT_W'(1);
      end
    end
    return dir;
  endfunction

endpackage

/* hdl/mbw_ram.sv */
// generic single-write single-read synchronous ram with a registered read port
`timescale 1ns / 1ps

module mbw_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/mbw_walk_ctrl.sv */
// walk sequencer: start clear sweep, stack top fetch, neighbor lookup, carve and push or pop
`timescale 1ns / 1ps

module mbw_walk_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [mbw_pkg::X_W-1:0]       start_x_i,
  input  logic [mbw_pkg::Y_W-1:0]       start_y_i,
  input  logic [mbw_pkg::RND_W-1:0]     random_value_i,
  input  logic                          out_free_i,
  output logic                          emit_valid_o,
  output mbw_pkg::result_t              emit_res_o,
  output mbw_pkg::vis_req_t             vis_req_o,
  input  logic                          vis_rdata_i,
  output mbw_pkg::stk_req_t             stk_req_o,
  input  logic [mbw_pkg::ENTRY_W-1:0]   stk_rdata_i
);

  mbw_pkg::state_e                    state_q, state_d;
  logic [mbw_pkg::COUNT_W-1:0]        count_q, count_d;
  logic [mbw_pkg::X_W-1:0]            top_x_q, top_x_d;
  logic [mbw_pkg::Y_W-1:0]            top_y_q, top_y_d;
  logic [mbw_pkg::RND_W-1:0]          rnd_q, rnd_d;
  logic [mbw_pkg::DIR_W-1:0]          dir_q, dir_d;
  logic                               rd_pend_q, rd_pend_d;
  logic [mbw_pkg::DIR_W-1:0]          rd_dir_q, rd_dir_d;
  logic [mbw_pkg::DIRS-1:0]           open_q, open_d;
  logic [mbw_pkg::DIR_W-1:0]          pick_q, pick_d;
  logic [mbw_pkg::CELL_AW-1:0]        clr_addr_q, clr_addr_d;

  logic [mbw_pkg::X_W:0]              cand_x [mbw_pkg::DIRS];
  logic [mbw_pkg::Y_W:0]              cand_y [mbw_pkg::DIRS];
  logic [mbw_pkg::DIRS-1:0]           inb;
  logic [mbw_pkg::DIRS-1:0]           open_cur;
  logic [mbw_pkg::DIR_W-1:0]          choice;
  logic [mbw_pkg::X_W-1:0]            wall_x;
  logic [mbw_pkg::Y_W-1:0]            wall_y;
  logic                               start_in_grid;

  // squares two away from the stack top, wrapping below zero lands out of bounds
  always_comb begin
    cand_x[mbw_pkg::DIR_UP]    = {1'b0, top_x_q};
    cand_y[mbw_pkg::DIR_UP]    = {1'b0, top_y_q} - (mbw_pkg::Y_W+1)'(2);
    cand_x[mbw_pkg::DIR_RIGHT] = {1'b0, top_x_q} + (mbw_pkg::X_W+1)'(2);
    cand_y[mbw_pkg::DIR_RIGHT] = {1'b0, top_y_q};
    cand_x[mbw_pkg::DIR_DOWN]  = {1'b0, top_x_q};
    cand_y[mbw_pkg::DIR_DOWN]  = {1'b0, top_y_q} + (mbw_pkg::Y_W+1)'(2);
    cand_x[mbw_pkg::DIR_LEFT]  = {1'b0, top_x_q} - (mbw_pkg::X_W+1)'(2);
    cand_y[mbw_pkg::DIR_LEFT]  = {1'b0, top_y_q};
    for (int d = 0; d < mbw_pkg::DIRS; d++) begin
      inb[d] = (cand_x[d] >= (mbw_pkg::X_W+1)'(mbw_pkg::EDGE_LO)) &&
               (cand_x[d] <= (mbw_pkg::X_W+1)'(mbw_pkg::MAX_X)) &&
               (cand_y[d] >= (mbw_pkg::Y_W+1)'(mbw_pkg::EDGE_LO)) &&
               (cand_y[d] <= (mbw_pkg::Y_W+1)'(mbw_pkg::MAX_Y)) &&
               cand_x[d][0] && cand_y[d][0];
    end
  end

  // fold in the visited bit arriving this cycle
  always_comb begin
    for (int d = 0; d < mbw_pkg::DIRS; d++) begin
      if (rd_pend_q && (rd_dir_q == mbw_pkg::DIR_W'(d))) begin
        open_cur[d] = inb[d] & ~vis_rdata_i;
      end else begin
        open_cur[d] = open_q[d];
      end
    end
    choice = mbw_pkg::pick_dir(open_cur, rnd_q);
  end

  // wall square between the top and the chosen target
  always_comb begin
    wall_x = top_x_q;
    wall_y = top_y_q;
    unique case (pick_q)
      mbw_pkg::DIR_UP:    wall_y = top_y_q - mbw_pkg::Y_W'(1);
      mbw_pkg::DIR_RIGHT: wall_x = top_x_q + mbw_pkg::X_W'(1);
      mbw_pkg::DIR_DOWN:  wall_y = top_y_q + mbw_pkg::Y_W'(1);
      mbw_pkg::DIR_LEFT:  wall_x = top_x_q - mbw_pkg::X_W'(1);
    endcase
  end

  assign start_in_grid = ({1'b0, top_x_q} < (mbw_pkg::X_W+1)'(mbw_pkg::GRID_COLUMNS)) &&
                         ({1'b0, top_y_q} < (mbw_pkg::Y_W+1)'(mbw_pkg::GRID_ROWS));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbw_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (!mode_i) begin
            state_d = mbw_pkg::ST_CLEAR;
          end else if (count_q == '0) begin
            state_d = mbw_pkg::ST_FIN;
          end else begin
            state_d = mbw_pkg::ST_TOP;
          end
        end
      end
      mbw_pkg::ST_CLEAR: begin
        if (clr_addr_q == mbw_pkg::CELL_AW'(mbw_pkg::CELLS - 1)) begin
          state_d = mbw_pkg::ST_START;
        end
      end
      mbw_pkg::ST_START: if (out_free_i) state_d = mbw_pkg::ST_IDLE;
      mbw_pkg::ST_FIN:   if (out_free_i) state_d = mbw_pkg::ST_IDLE;
      mbw_pkg::ST_TOP:   state_d = mbw_pkg::ST_LOOK;
      mbw_pkg::ST_LOOK: begin
        if (dir_q == mbw_pkg::DIR_LEFT) begin
          state_d = mbw_pkg::ST_CHOOSE;
        end
      end
      mbw_pkg::ST_CHOOSE: begin
        state_d = (|open_cur) ? mbw_pkg::ST_WALL : mbw_pkg::ST_POP;
      end
      mbw_pkg::ST_POP:  if (out_free_i) state_d = mbw_pkg::ST_IDLE;
      mbw_pkg::ST_WALL: if (out_free_i) state_d = mbw_pkg::ST_TGT;
      mbw_pkg::ST_TGT:  if (out_free_i) state_d = mbw_pkg::ST_IDLE;
      default:          state_d = mbw_pkg::ST_IDLE;
    endcase
  end

  // outputs, memory requests and datapath updates
  always_comb begin
    in_ready_o   = 1'b0;
    emit_valid_o = 1'b0;
    emit_res_o   = '{ev: mbw_pkg::EV_CARVED, x: '0, y: '0, last: 1'b1};
    vis_req_o    = '0;
    stk_req_o    = '0;
    count_d      = count_q;
    top_x_d      = top_x_q;
    top_y_d      = top_y_q;
    rnd_d        = rnd_q;
    dir_d        = dir_q;
    rd_pend_d    = 1'b0;
    rd_dir_d     = rd_dir_q;
    open_d       = open_cur;
    pick_d       = pick_q;
    clr_addr_d   = clr_addr_q;
    unique case (state_q)
      mbw_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          top_x_d    = start_x_i;
          top_y_d    = start_y_i;
          rnd_d      = random_value_i;
          clr_addr_d = '0;
          // fetch the stack top for a step
          if (mode_i && (count_q != '0)) begin
            stk_req_o.re    = 1'b1;
            stk_req_o.raddr = mbw_pkg::STACK_AW'(count_q - mbw_pkg::COUNT_W'(1));
          end
        end
      end
      mbw_pkg::ST_CLEAR: begin
        vis_req_o.we    = 1'b1;
        vis_req_o.waddr = clr_addr_q;
        vis_req_o.wdata = 1'b0;
        clr_addr_d      = clr_addr_q + mbw_pkg::CELL_AW'(1);
      end
      mbw_pkg::ST_START: begin
        if (out_free_i) begin
          emit_valid_o    = 1'b1;
          emit_res_o      = '{ev: mbw_pkg::EV_CARVED, x: top_x_q, y: top_y_q, last: 1'b1};
          vis_req_o.we    = start_in_grid;
          vis_req_o.waddr = mbw_pkg::cell_addr({1'b0, top_x_q}, {1'b0, top_y_q});
          vis_req_o.wdata = 1'b1;
          stk_req_o.we    = 1'b1;
          stk_req_o.waddr = '0;
          stk_req_o.wdata = {top_y_q, top_x_q};
          count_d         = mbw_pkg::COUNT_W'(1);
        end
      end
      mbw_pkg::ST_FIN: begin
        if (out_free_i) begin
          emit_valid_o = 1'b1;
          emit_res_o   = '{ev: mbw_pkg::EV_FINISH, x: '0, y: '0, last: 1'b1};
          count_d      = '0;
        end
      end
      mbw_pkg::ST_TOP: begin
        top_x_d = stk_rdata_i[mbw_pkg::X_W-1:0];
        top_y_d = stk_rdata_i[mbw_pkg::ENTRY_W-1:mbw_pkg::X_W];
        dir_d   = mbw_pkg::DIR_UP;
        open_d  = '0;
      end
      mbw_pkg::ST_LOOK: begin
        // one neighbor read per cycle, skipped when out of bounds
        vis_req_o.re    = inb[dir_q];
        vis_req_o.raddr = mbw_pkg::cell_addr(cand_x[dir_q], cand_y[dir_q]);
        rd_pend_d       = 1'b1;
        rd_dir_d        = dir_q;
        dir_d           = dir_q + mbw_pkg::DIR_W'(1);
      end
      mbw_pkg::ST_CHOOSE: begin
        pick_d = choice;
      end
      mbw_pkg::ST_POP: begin
        if (out_free_i) begin
          emit_valid_o = 1'b1;
          emit_res_o   = '{ev: (count_q == mbw_pkg::COUNT_W'(1)) ? mbw_pkg::EV_FINISH
                                                                 : mbw_pkg::EV_BACK,
                           x: '0, y: '0, last: 1'b1};
          count_d      = count_q - mbw_pkg::COUNT_W'(1);
        end
      end
      mbw_pkg::ST_WALL: begin
        if (out_free_i) begin
          emit_valid_o    = 1'b1;
          emit_res_o      = '{ev: mbw_pkg::EV_CARVED, x: wall_x, y: wall_y, last: 1'b0};
          vis_req_o.we    = 1'b1;
          vis_req_o.waddr = mbw_pkg::cell_addr({1'b0, wall_x}, {1'b0, wall_y});
          vis_req_o.wdata = 1'b1;
        end
      end
      mbw_pkg::ST_TGT: begin
        if (out_free_i) begin
          emit_valid_o    = 1'b1;
          emit_res_o      = '{ev: mbw_pkg::EV_CARVED,
                              x: cand_x[pick_q][mbw_pkg::X_W-1:0],
                              y: cand_y[pick_q][mbw_pkg::Y_W-1:0],
                              last: 1'b1};
          vis_req_o.we    = 1'b1;
          vis_req_o.waddr = mbw_pkg::cell_addr(cand_x[pick_q], cand_y[pick_q]);
          vis_req_o.wdata = 1'b1;
          // push the target unless the stack is full
          if (count_q < mbw_pkg::COUNT_W'(mbw_pkg::STACK_DEPTH)) begin
            stk_req_o.we    = 1'b1;
            stk_req_o.waddr = mbw_pkg::STACK_AW'(count_q);
            stk_req_o.wdata = {cand_y[pick_q][mbw_pkg::Y_W-1:0],
                               cand_x[pick_q][mbw_pkg::X_W-1:0]};
            count_d         = count_q + mbw_pkg::COUNT_W'(1);
          end
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mbw_pkg::ST_IDLE;
      count_q   <= '0;
      rd_pend_q <= 1'b0;
      pick_q    <= mbw_pkg::DIR_UP;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_pend_q <= rd_pend_d;
      pick_q    <= pick_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    top_x_q    <= top_x_d;
    top_y_q    <= top_y_d;
    rnd_q      <= rnd_d;
    dir_q      <= dir_d;
    rd_dir_q   <= rd_dir_d;
    open_q     <= open_d;
    clr_addr_q <= clr_addr_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mbw_pkg::COUNT_W'(mbw_pkg::STACK_DEPTH))
    else $error("stack count above depth");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_valid_o |-> out_free_i)
    else $error("result issued while output register busy");

  a_vis_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(vis_req_o.we && vis_req_o.re))
    else $error("visited map read and written in one cycle");

  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mbw_pkg::ST_TGT && out_free_i &&
     count_q < mbw_pkg::COUNT_W'(mbw_pkg::STACK_DEPTH))
    |=> count_q == $past(count_q) + mbw_pkg::COUNT_W'(1))
    else $error("push did not grow the stack");

  a_last_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mbw_pkg::ST_CHOOSE) |-> (rd_pend_q && rd_dir_q == mbw_pkg::DIR_LEFT))
    else $error("choice made before the last neighbor read returned");
`endif

endmodule

/* hdl/maze_backtracker_walk.sv */
// top level of the maze walk: memories, sequencer and output register
`timescale 1ns / 1ps

// Randomized depth-first maze carver over an 80 x 21 grid.
// Input request (valid/ready): mode 0 starts a maze at start_x/start_y, mode 1
// takes one walk step using random_value to choose among open directions.
// Output request (valid/ready): event_res, cell_x, cell_y, last; a step that
// carves gives two results (wall square, then target with last set), every
// other request gives one result with last set.
// Timing: a start request sweeps the visited map one square per cycle. A step
// fetches the stack top, then the four neighbor lookups go one per cycle
// through the single read port of the visited map; a step on an empty stack
// gives its finish result with no lookups.
// One request is worked on at a time; in_ready_o is high only while idle.
// The last result sits in an output register, so the next request is taken
// while it waits; a stalled receiver holds the sequencer before it issues
// the next result and its memory writes.
// Reset empties the stack and the output register; the visited map is
// cleared by every start request, not by reset.

module maze_backtracker_walk (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mode_i,
  input  logic [mbw_pkg::X_W-1:0]        start_x_i,
  input  logic [mbw_pkg::Y_W-1:0]        start_y_i,
  input  logic [mbw_pkg::RND_W-1:0]      random_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mbw_pkg::EV_W-1:0]       event_res_o,
  output logic [mbw_pkg::X_W-1:0]        cell_x_o,
  output logic [mbw_pkg::Y_W-1:0]        cell_y_o,
  output logic                           last_o
);

  mbw_pkg::vis_req_t                vis_req;
  mbw_pkg::stk_req_t                stk_req;
  logic                             vis_rdata;
  logic [mbw_pkg::ENTRY_W-1:0]      stk_rdata;
  logic                             out_free;
  logic                             emit_valid;
  mbw_pkg::result_t                 emit_res;
  logic                             out_valid_q, out_valid_d;
  mbw_pkg::result_t                 out_res_q;

  // visited map, one bit per square
  mbw_ram #(
    .DEPTH (mbw_pkg::CELLS),
    .WIDTH (1)
  ) u_visited (
    .clk_i   (clk_i),
    .we_i    (vis_req.we),
    .waddr_i (vis_req.waddr),
    .wdata_i (vis_req.wdata),
    .re_i    (vis_req.re),
    .raddr_i (vis_req.raddr),
    .rdata_o (vis_rdata)
  );

  // path stack of square coordinates
  mbw_ram #(
    .DEPTH (mbw_pkg::STACK_DEPTH),
    .WIDTH (mbw_pkg::ENTRY_W)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_req.we),
    .waddr_i (stk_req.waddr),
    .wdata_i (stk_req.wdata),
    .re_i    (stk_req.re),
    .raddr_i (stk_req.raddr),
    .rdata_o (stk_rdata)
  );

  mbw_walk_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .random_value_i (random_value_i),
    .out_free_i     (out_free),
    .emit_valid_o   (emit_valid),
    .emit_res_o     (emit_res),
    .vis_req_o      (vis_req),
    .vis_rdata_i    (vis_rdata),
    .stk_req_o      (stk_req),
    .stk_rdata_i    (stk_rdata)
  );

  // output register accepts a new result when empty or being drained
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_valid) begin
      out_res_q <= emit_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = out_res_q.ev;
  assign cell_x_o    = out_res_q.x;
  assign cell_y_o    = out_res_q.y;
  assign last_o      = out_res_q.last;

endmodule
